// ===== rtl/core/aisc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisc_pkg: shared types and constants for the analog input scaler
// Fixed-point format, breakpoint table geometry, register indexes and the
// request/response structs of the shared multiply-add unit.
// ----------------------------------------------------------------------------
package aisc_pkg;

  // Q16.16 values
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;

  // Breakpoint table geometry
  localparam int TBL_DEPTH = 64;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_AW = 3;
  typedef enum logic [CFG_AW-1:0] {
    REG_DEVICE_MODE   = 3'd0,
    REG_DEVICE_OFFSET = 3'd1,
    REG_DEVICE_GAIN   = 3'd2,
    REG_USE_TABLE     = 3'd3,
    REG_SENSOR_C0     = 3'd4,
    REG_SENSOR_C1     = 3'd5,
    REG_SENSOR_C2     = 3'd6,
    REG_TABLE_POINTS  = 3'd7
  } aisc_reg_t;

  // Device modes
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;

  // Request op codes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Multiply-add request: (a*b [>>> FRAC_BITS]) + addend, saturated
  typedef struct packed {
    logic                    go;
    logic                    frac;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] addend;
  } mac_req_t;

  typedef struct packed {
    logic                    done;
    logic                    ovf;
    logic signed [VAL_W-1:0] value;
  } mac_rsp_t;

endpackage

// ===== rtl/core/analog_input_scaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_input_scaler_unit: raw sample to signal and actual value
// Device stage (gain*raw + offset or held signal), then a quadratic Horner
// polynomial or a binary search over a breakpoint table plus segment line.
//
//   channel   ports                        handshake
//   request   start, busy, in_*            taken when start & !busy
//   result    out_valid, out_*             one-cycle strobe, no stall
//   config    cfg_we, cfg_addr, cfg_wdata  written when cfg_we
//
// A table write is taken in idle and leaves the unit idle. A conversion runs
// the device multiply-add only in device mode 1, then the two Horner
// multiply-adds, or up to six search probes through the single read port and
// the segment multiply-add, all on the shared unit. Reset (rst_n low,
// synchronous) restores the configuration, state and held signal registers;
// the table is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module analog_input_scaler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic signed [15:0]                in_raw_sample,
  input  logic [5:0]                        in_entry_index,
  input  logic signed [31:0]                in_entry_breakpoint,
  input  logic signed [31:0]                in_entry_intercept,
  input  logic signed [31:0]                in_entry_slope,
  output logic                              out_valid,
  output logic signed [31:0]                out_signal_value,
  output logic signed [31:0]                out_actual_value,
  output logic                              out_status,
  output logic                              out_overflow,
  input  logic                              cfg_we,
  input  logic [aisc_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [31:0]                       cfg_wdata
);
  import aisc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEV   = 13'b0000000000010,
    S_DEV_W = 13'b0000000000100,
    S_SIG   = 13'b0000000001000,
    S_P1    = 13'b0000000010000,
    S_P1_W  = 13'b0000000100000,
    S_P2    = 13'b0000001000000,
    S_P2_W  = 13'b0000010000000,
    S_SRCH  = 13'b0000100000000,
    S_CMP   = 13'b0001000000000,
    S_SEG   = 13'b0010000000000,
    S_SEG_W = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  // configuration registers
  logic [1:0]              dev_mode_r;
  logic signed [VAL_W-1:0] dev_offset_r;
  logic signed [VAL_W-1:0] dev_gain_r;
  logic                    use_table_r;
  logic signed [VAL_W-1:0] c0_r;
  logic signed [VAL_W-1:0] c1_r;
  logic signed [VAL_W-1:0] c2_r;
  logic [CNT_W-1:0]        points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_mode_r   <= MODE_HOLD;
      dev_offset_r <= '0;
      dev_gain_r   <= VAL_W'(1) << FRAC_BITS;
      use_table_r  <= 1'b0;
      c0_r         <= '0;
      c1_r         <= VAL_W'(1) << FRAC_BITS;
      c2_r         <= '0;
      points_r     <= '0;
    end else if (cfg_we) begin
      unique case (aisc_reg_t'(cfg_addr))
        REG_DEVICE_MODE:   dev_mode_r   <= cfg_wdata[1:0];
        REG_DEVICE_OFFSET: dev_offset_r <= cfg_wdata;
        REG_DEVICE_GAIN:   dev_gain_r   <= cfg_wdata;
        REG_USE_TABLE:     use_table_r  <= cfg_wdata[0];
        REG_SENSOR_C0:     c0_r         <= cfg_wdata;
        REG_SENSOR_C1:     c1_r         <= cfg_wdata;
        REG_SENSOR_C2:     c2_r         <= cfg_wdata;
        REG_TABLE_POINTS:  points_r     <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t                  state_r, state_nxt;
  logic signed [15:0]      raw_r, raw_nxt;
  logic signed [VAL_W-1:0] held_r, held_nxt;
  logic                    status_r, status_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    dev_upd_r, dev_upd_nxt;
  logic [CNT_W-1:0]        first_r, first_nxt;
  logic [CNT_W-1:0]        last_r, last_nxt;
  logic [CNT_W-1:0]        mid_r, mid_nxt;

  logic                    accept;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic                    probe;
  logic [CNT_W-1:0]        points_clamped;
  logic [TBL_AW-1:0]       rd_addr;
  logic signed [VAL_W-1:0] rd_bp;
  logic signed [VAL_W-1:0] rd_icpt;
  logic signed [VAL_W-1:0] rd_slope;
  mac_req_t                mac_req;
  mac_rsp_t                mac_rsp;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // search bounds
  assign points_clamped = (points_r > CNT_W'(TBL_DEPTH)) ? CNT_W'(TBL_DEPTH) : points_r;
  assign mid_sum        = (CNT_W+1)'(first_r) + (CNT_W+1)'(last_r);
  assign mid            = mid_sum[CNT_W:1];
  assign probe          = ((CNT_W+1)'(last_r) > ((CNT_W+1)'(first_r) + (CNT_W+1)'(1)));
  assign rd_addr        = (state_r == S_SRCH && probe) ? mid[TBL_AW-1:0]
                                                       : first_r[TBL_AW-1:0];

  // next-state and datapath control
  always_comb begin
    state_nxt   = state_r;
    raw_nxt     = raw_r;
    held_nxt    = held_r;
    status_nxt  = status_r;
    ovf_nxt     = ovf_r;
    dev_upd_nxt = dev_upd_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    mid_nxt     = mid_r;
    mac_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_CONVERT) begin
          raw_nxt     = in_raw_sample;
          status_nxt  = (dev_mode_r != MODE_HOLD) && (dev_mode_r != MODE_LINEAR);
          ovf_nxt     = 1'b0;
          dev_upd_nxt = (dev_mode_r == MODE_LINEAR);
          first_nxt   = '0;
          last_nxt    = points_clamped;
          state_nxt   = (dev_mode_r == MODE_LINEAR) ? S_DEV : S_SIG;
        end
      end
      // gain*raw + offset, raw is an integer count
      S_DEV: begin
        mac_req.go     = 1'b1;
        mac_req.frac   = 1'b0;
        mac_req.a      = VAL_W'(raw_r);
        mac_req.b      = dev_gain_r;
        mac_req.addend = dev_offset_r;
        state_nxt      = S_DEV_W;
      end
      S_DEV_W: state_nxt = S_SIG;
      S_SIG: begin
        if (dev_upd_r) begin
          held_nxt = mac_rsp.value;
          ovf_nxt  = ovf_r | mac_rsp.ovf;
        end
        state_nxt = use_table_r ? S_SRCH : S_P1;
      end
      // Horner: (s*c2 + c1)*s + c0
      S_P1: begin
        mac_req.go     = 1'b1;
        mac_req.frac   = 1'b1;
        mac_req.a      = held_r;
        mac_req.b      = c2_r;
        mac_req.addend = c1_r;
        state_nxt      = S_P1_W;
      end
      S_P1_W: state_nxt = S_P2;
      S_P2: begin
        ovf_nxt        = ovf_r | mac_rsp.ovf;
        mac_req.go     = 1'b1;
        mac_req.frac   = 1'b1;
        mac_req.a      = held_r;
        mac_req.b      = mac_rsp.value;
        mac_req.addend = c0_r;
        state_nxt      = S_P2_W;
      end
      S_P2_W: state_nxt = S_OUT;
      // binary search: probe breakpoint at mid or fetch segment at first
      S_SRCH: begin
        if (probe) begin
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_SEG;
        end
      end
      S_CMP: begin
        if (held_r < rd_bp) begin
          last_nxt = mid_r;
        end else begin
          first_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      // intercept + s*slope
      S_SEG: begin
        mac_req.go     = 1'b1;
        mac_req.frac   = 1'b1;
        mac_req.a      = held_r;
        mac_req.b      = rd_slope;
        mac_req.addend = rd_icpt;
        state_nxt      = S_SEG_W;
      end
      S_SEG_W: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r     <= raw_nxt;
    status_r  <= status_nxt;
    ovf_r     <= ovf_nxt;
    dev_upd_r <= dev_upd_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    mid_r     <= mid_nxt;
  end

  // shared multiply-add unit
  aisc_mac_unit u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mac_req),
    .rsp_o (mac_rsp)
  );

  // breakpoint table
  aisc_table u_table (
    .clk      (clk),
    .wr_en    (accept && in_op == OP_WRITE),
    .wr_addr  (in_entry_index[TBL_AW-1:0]),
    .wr_bp    (in_entry_breakpoint),
    .wr_icpt  (in_entry_intercept),
    .wr_slope (in_entry_slope),
    .rd_addr  (rd_addr),
    .rd_bp    (rd_bp),
    .rd_icpt  (rd_icpt),
    .rd_slope (rd_slope)
  );

  // result strobe
  assign out_valid        = (state_r == S_OUT);
  assign out_signal_value = held_r;
  assign out_actual_value = mac_rsp.value;
  assign out_status       = status_r;
  assign out_overflow     = ovf_r | mac_rsp.ovf;

  // checks
  a_out_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mac_rsp.done)
    else $error("result strobe without a finished multiply-add");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result strobe not followed by idle");

  a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (mid_r > first_r) && (mid_r < last_r))
    else $error("search probe outside bounds");

  a_held_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(held_r)) |-> ($past(state_r) == S_SIG) && $past(dev_upd_r))
    else $error("held signal changed outside the device update");

endmodule

// ===== rtl/core/aisc_mac_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisc_mac_unit: shared multiply-add-saturate unit
// Two-stage: 32x32 signed product is registered, then optionally floored by
// FRAC_BITS, added to the addend and saturated to 32 bits with a flag.
// ----------------------------------------------------------------------------
module aisc_mac_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  aisc_pkg::mac_req_t req_i,
  output aisc_pkg::mac_rsp_t rsp_o
);
  import aisc_pkg::*;

  localparam int PW = 2 * VAL_W;

  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    prod_nxt;
  logic                    frac_r;
  logic signed [VAL_W-1:0] addend_r;
  logic                    go_r;
  logic                    done_r;
  logic signed [VAL_W-1:0] res_r;
  logic signed [VAL_W-1:0] res_nxt;
  logic                    ovf_r;
  logic                    ovf_nxt;
  logic signed [PW-1:0]    shf;
  logic signed [PW:0]      sum;

  // stage 1: product
  assign prod_nxt = req_i.a * req_i.b;

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    frac_r   <= req_i.frac;
    addend_r <= req_i.addend;
  end

  // stage 2: floor shift (arithmetic shift rounds toward minus infinity), add, saturate
  always_comb begin
    shf = frac_r ? (prod_r >>> FRAC_BITS) : prod_r;
    sum = (PW+1)'(shf) + (PW+1)'(addend_r);
    ovf_nxt = 1'b0;
    res_nxt = sum[VAL_W-1:0];
    if (sum[PW:VAL_W-1] != {(PW-VAL_W+2){sum[PW]}}) begin
      ovf_nxt = 1'b1;
      res_nxt = sum[PW] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    ovf_r <= ovf_nxt;
  end

  // valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      go_r   <= req_i.go;
      done_r <= go_r;
    end
  end

  assign rsp_o.done  = done_r;
  assign rsp_o.ovf   = ovf_r;
  assign rsp_o.value = res_r;

endmodule

// ===== rtl/core/aisc_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisc_table: breakpoint / segment memories
// One write port for whole entries, one registered read port shared by the
// breakpoint search and the segment fetch.
// ----------------------------------------------------------------------------
module aisc_table (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [aisc_pkg::TBL_AW-1:0]       wr_addr,
  input  logic signed [aisc_pkg::VAL_W-1:0] wr_bp,
  input  logic signed [aisc_pkg::VAL_W-1:0] wr_icpt,
  input  logic signed [aisc_pkg::VAL_W-1:0] wr_slope,
  input  logic [aisc_pkg::TBL_AW-1:0]       rd_addr,
  output logic signed [aisc_pkg::VAL_W-1:0] rd_bp,
  output logic signed [aisc_pkg::VAL_W-1:0] rd_icpt,
  output logic signed [aisc_pkg::VAL_W-1:0] rd_slope
);
  import aisc_pkg::*;

  logic [VAL_W-1:0]   bp_mem  [TBL_DEPTH];
  logic [2*VAL_W-1:0] seg_mem [TBL_DEPTH];
  logic [VAL_W-1:0]   bp_r;
  logic [2*VAL_W-1:0] seg_r;

  // write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bp_mem[wr_addr]  <= wr_bp;
      seg_mem[wr_addr] <= {wr_icpt, wr_slope};
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    bp_r  <= bp_mem[rd_addr];
    seg_r <= seg_mem[rd_addr];
  end

  assign rd_bp    = bp_r;
  assign rd_icpt  = seg_r[2*VAL_W-1:VAL_W];
  assign rd_slope = seg_r[VAL_W-1:0];

endmodule

// ===== bench/analog_input_scaler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_input_scaler_unit_tb: self-checking bench for the analog input scaler
// Runs directed conversions at the field extremes, loading the breakpoint
// table along the way, then randomized phases across configurations and sender
// idle levels. A shadow model predicts every reading, and each strobed result
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module analog_input_scaler_unit_tb;
  import aisc_pkg::*;

  localparam int          PAUSE_CYCLES    = 32;      // longer than the worst conversion
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int          RANDOM_PHASES   = 12;
  localparam int          ITEMS_PER_PHASE = 75;

  // Device modes with no linear polynomial behind them
  localparam logic [1:0] MODE_RSVD2 = 2'd2;
  localparam logic [1:0] MODE_RSVD3 = 2'd3;

  typedef struct {
    logic                    op;
    logic signed [15:0]      raw_sample;
    logic [TBL_AW-1:0]       entry_index;
    logic signed [VAL_W-1:0] entry_breakpoint;
    logic signed [VAL_W-1:0] entry_intercept;
    logic signed [VAL_W-1:0] entry_slope;
  } scaler_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] signal_value;
    logic signed [VAL_W-1:0] actual_value;
    logic                    status;
    logic                    overflow;
  } reading_t;

  // DUT connections, all driven from time zero
  logic                    clk                 = 1'b0;
  logic                    rst_n               = 1'b0;
  logic                    start               = 1'b0;
  logic                    busy;
  logic                    in_op               = OP_CONVERT;
  logic signed [15:0]      in_raw_sample       = '0;
  logic [5:0]              in_entry_index      = '0;
  logic signed [31:0]      in_entry_breakpoint = '0;
  logic signed [31:0]      in_entry_intercept  = '0;
  logic signed [31:0]      in_entry_slope      = '0;
  logic                    out_valid;
  logic signed [31:0]      out_signal_value;
  logic signed [31:0]      out_actual_value;
  logic                    out_status;
  logic                    out_overflow;
  logic                    cfg_we              = 1'b0;
  logic [CFG_AW-1:0]       cfg_addr            = '0;
  logic [31:0]             cfg_wdata           = '0;

  // Shadow registers, reset values
  logic [1:0]              mode_q       = MODE_HOLD;
  logic signed [VAL_W-1:0] dev_offset_q = '0;
  logic signed [VAL_W-1:0] dev_gain_q   = 32'sd65536;
  logic                    tbl_en_q     = 1'b0;
  logic signed [VAL_W-1:0] c0_q         = '0;
  logic signed [VAL_W-1:0] c1_q         = 32'sd65536;
  logic signed [VAL_W-1:0] c2_q         = '0;
  logic [6:0]              tbl_points_q = '0;

  // Shadow datapath state
  logic signed [VAL_W-1:0] held_signal = '0;
  logic signed [VAL_W-1:0] tbl_bp    [TBL_DEPTH];
  logic signed [VAL_W-1:0] tbl_icpt  [TBL_DEPTH];
  logic signed [VAL_W-1:0] tbl_slope [TBL_DEPTH];

  // Breakpoints as issued by the stimulus, used to keep tables ordered
  logic signed [VAL_W-1:0] stim_bp [TBL_DEPTH];

  scaler_req_t pending_requests[$];
  reading_t    expected_readings[$];
  scaler_req_t in_flight;
  reading_t    oldest;
  int          queued_count   = 0;
  int          accepted_count = 0;
  int          idle_pct       = 0;
  int          errors         = 0;
  int unsigned cycle_count    = 0;

  analog_input_scaler_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_raw_sample       (in_raw_sample),
    .in_entry_index      (in_entry_index),
    .in_entry_breakpoint (in_entry_breakpoint),
    .in_entry_intercept  (in_entry_intercept),
    .in_entry_slope      (in_entry_slope),
    .out_valid           (out_valid),
    .out_signal_value    (out_signal_value),
    .out_actual_value    (out_actual_value),
    .out_status          (out_status),
    .out_overflow        (out_overflow),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------

  // Clamp to signed 32 bits, flag any clamp
  function automatic logic signed [VAL_W-1:0] sat_q(input longint x, inout bit ovf);
    if (x > longint'(32'sh7fffffff)) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -longint'(64'sd2147483648)) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return x[VAL_W-1:0];
  endfunction

  // Q*Q product floored back to Q
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // --------------------------------------------------------------------------
  // Shadow model: table writes update the table, conversions yield a reading
  // --------------------------------------------------------------------------
  task automatic predict_request(input scaler_req_t r);
    reading_t rd;
    longint   acc;
    int       lo;
    int       hi;
    int       mid;
    bit       ovf;
    if (r.op == OP_WRITE) begin
      tbl_bp[r.entry_index]    = r.entry_breakpoint;
      tbl_icpt[r.entry_index]  = r.entry_intercept;
      tbl_slope[r.entry_index] = r.entry_slope;
    end else begin
      ovf       = 1'b0;
      rd.status = 1'b0;
      if (mode_q == MODE_LINEAR) begin
        held_signal = sat_q(longint'(r.raw_sample) * longint'(dev_gain_q)
                            + longint'(dev_offset_q), ovf);
      end else if (mode_q != MODE_HOLD) begin
        rd.status = 1'b1;
      end
      if (tbl_en_q) begin
        // search keeps bp[lo] <= signal < bp[hi]
        lo = 0;
        hi = (int'(tbl_points_q) > TBL_DEPTH) ? TBL_DEPTH : int'(tbl_points_q);
        while (hi > lo + 1) begin
          mid = (lo + hi) / 2;
          if (held_signal < tbl_bp[mid]) hi = mid;
          else lo = mid;
        end
        acc = longint'(sat_q(longint'(tbl_icpt[lo])
                             + qmul(longint'(held_signal), longint'(tbl_slope[lo])), ovf));
      end else begin
        acc = longint'(sat_q(qmul(longint'(held_signal), longint'(c2_q))
                             + longint'(c1_q), ovf));
        acc = longint'(sat_q(qmul(longint'(held_signal), acc) + longint'(c0_q), ovf));
      end
      rd.signal_value = held_signal;
      rd.actual_value = acc[VAL_W-1:0];
      rd.overflow     = ovf;
      expected_readings.push_back(rd);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: holds start until the block takes the request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(in_flight);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_flight            = pending_requests.pop_front();
          start               <= 1'b1;
          in_op               <= in_flight.op;
          in_raw_sample       <= in_flight.raw_sample;
          in_entry_index      <= in_flight.entry_index;
          in_entry_breakpoint <= in_flight.entry_breakpoint;
          in_entry_intercept  <= in_flight.entry_intercept;
          in_entry_slope      <= in_flight.entry_slope;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: signal_value %0d actual_value %0d",
               out_signal_value, out_actual_value);
        errors++;
      end else begin
        oldest = expected_readings.pop_front();
        if (out_signal_value !== oldest.signal_value) begin
          $error("signal_value: expected %0d, actual %0d",
                 oldest.signal_value, out_signal_value);
          errors++;
        end
        if (out_actual_value !== oldest.actual_value) begin
          $error("actual_value: expected %0d, actual %0d",
                 oldest.actual_value, out_actual_value);
          errors++;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, out_status);
          errors++;
        end
        if (out_overflow !== oldest.overflow) begin
          $error("overflow: expected %0d, actual %0d", oldest.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("analog_input_scaler_unit_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Register write, mirrored into the shadow once it has landed
  task automatic set_reg(input aisc_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DEVICE_MODE:   mode_q       = val[1:0];
      REG_DEVICE_OFFSET: dev_offset_q = val;
      REG_DEVICE_GAIN:   dev_gain_q   = val;
      REG_USE_TABLE:     tbl_en_q     = val[0];
      REG_SENSOR_C0:     c0_q         = val;
      REG_SENSOR_C1:     c1_q         = val;
      REG_SENSOR_C2:     c2_q         = val;
      REG_TABLE_POINTS:  tbl_points_q = val[6:0];
      default: ;
    endcase
  endtask

  // Wait until every request is taken and answered, then let a write finish
  task automatic drain_and_pause();
    while (accepted_count != queued_count || expected_readings.size() != 0)
      @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  task automatic push_convert(input logic signed [15:0] raw);
    scaler_req_t r;
    r.op               = OP_CONVERT;
    r.raw_sample       = raw;
    r.entry_index      = TBL_AW'($urandom());
    r.entry_breakpoint = $urandom();
    r.entry_intercept  = $urandom();
    r.entry_slope      = $urandom();
    pending_requests.push_back(r);
    queued_count++;
  endtask

  task automatic push_entry(input logic [TBL_AW-1:0] idx, input logic signed [31:0] bp,
                            input logic signed [31:0] icpt, input logic signed [31:0] slope);
    scaler_req_t r;
    r.op               = OP_WRITE;
    r.raw_sample       = 16'($urandom());
    r.entry_index      = idx;
    r.entry_breakpoint = bp;
    r.entry_intercept  = icpt;
    r.entry_slope      = slope;
    stim_bp[idx]       = bp;
    pending_requests.push_back(r);
    queued_count++;
  endtask

  // Q16.16 value, mostly of moderate magnitude, sometimes an extreme
  function automatic logic signed [31:0] rand_q();
    int unsigned        k;
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7fffffff;
          1:       v = 32'sh80000000;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end
      default: begin
        k = $urandom_range(4, 22);
        v = $urandom_range(0, 1 << k);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] rand_raw();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom());
    endcase
  endfunction

  // Full table load; the entries in use ascend across the signal range
  task automatic load_table();
    int          used;
    int          vals[$];
    longint      span;
    longint      lo;
    longint      hi;
    int unsigned width;
    used = (int'(tbl_points_q) > TBL_DEPTH) ? TBL_DEPTH : int'(tbl_points_q);
    if (used < 1) used = 1;
    span = 64'sd32768 * ((dev_gain_q < 0) ? -longint'(dev_gain_q) : longint'(dev_gain_q));
    if (span < 65536) span = 65536;
    lo = longint'(dev_offset_q) - span;
    hi = longint'(dev_offset_q) + span;
    if (lo < -64'sd2147483648) lo = -64'sd2147483648;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    width = 32'(hi - lo);
    for (int i = 0; i < used; i++) vals.push_back(int'(lo + longint'($urandom_range(0, width))));
    vals.sort();
    for (int i = 0; i < TBL_DEPTH; i++)
      push_entry(TBL_AW'(i), (i < used) ? vals[i] : int'($urandom()), rand_q(), rand_q());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int          pick;
    logic [31:0] val;
    logic [5:0]  idx;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: hold mode on a zero signal
    push_convert(16'sh8000);
    push_convert(16'sh7fff);
    load_table();
    drain_and_pause();

    // Linear device stage at unit gain
    set_reg(REG_DEVICE_MODE, 32'(MODE_LINEAR));
    push_convert(16'sh7fff);
    push_convert(16'sh8000);
    push_convert(16'sh0000);
    push_convert(-16'sd1);
    push_convert(16'sd1);
    drain_and_pause();

    // Device stage saturation, both signs
    set_reg(REG_DEVICE_GAIN, 32'h7fffffff);
    set_reg(REG_DEVICE_OFFSET, 32'h7fffffff);
    push_convert(16'sh7fff);
    push_convert(16'sh8000);
    push_convert(16'sh0000);
    drain_and_pause();
    set_reg(REG_DEVICE_GAIN, 32'h80000000);
    set_reg(REG_DEVICE_OFFSET, 32'h80000000);
    push_convert(16'sh7fff);
    push_convert(16'sh8000);
    drain_and_pause();

    // Horner polynomial with extreme coefficients
    set_reg(REG_DEVICE_GAIN, 32'h00010000);
    set_reg(REG_DEVICE_OFFSET, 32'h00000000);
    set_reg(REG_SENSOR_C2, 32'h7fffffff);
    set_reg(REG_SENSOR_C1, 32'h80000000);
    set_reg(REG_SENSOR_C0, 32'h7fffffff);
    push_convert(16'sh7fff);
    push_convert(16'sh8000);
    push_convert(16'sd5);
    drain_and_pause();

    // Table path: short table, oversized count, full table
    set_reg(REG_USE_TABLE, 32'd1);
    set_reg(REG_TABLE_POINTS, 32'd0);
    push_convert(16'sd100);
    drain_and_pause();
    set_reg(REG_TABLE_POINTS, 32'd1);
    push_convert(-16'sd100);
    drain_and_pause();
    set_reg(REG_TABLE_POINTS, 32'd127);
    push_convert(16'sh7fff);
    push_convert(16'sh8000);
    drain_and_pause();
    set_reg(REG_TABLE_POINTS, TBL_DEPTH);
    push_convert(16'sd0);
    drain_and_pause();

    // Invalid modes keep the held signal, then plain hold
    set_reg(REG_DEVICE_MODE, 32'(MODE_RSVD2));
    push_convert(16'sd1234);
    drain_and_pause();
    set_reg(REG_DEVICE_MODE, 32'(MODE_RSVD3));
    push_convert(-16'sd5);
    drain_and_pause();
    set_reg(REG_DEVICE_MODE, 32'(MODE_HOLD));
    push_convert(16'sd7);
    drain_and_pause();

    // Randomized phases
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        1:       idle_pct = 78;
        3:       idle_pct = 34;
        default: idle_pct = 0;
      endcase

      pick = $urandom_range(0, 9);
      if (pick < 6)       val = 32'(MODE_LINEAR);
      else if (pick < 8)  val = 32'(MODE_HOLD);
      else if (pick == 8) val = 32'(MODE_RSVD2);
      else                val = 32'(MODE_RSVD3);
      set_reg(REG_DEVICE_MODE, val);
      set_reg(REG_DEVICE_OFFSET, rand_q());
      set_reg(REG_DEVICE_GAIN, rand_q());
      set_reg(REG_USE_TABLE, $urandom_range(0, 1));
      set_reg(REG_SENSOR_C0, rand_q());
      set_reg(REG_SENSOR_C1, rand_q());
      set_reg(REG_SENSOR_C2, rand_q());
      case ($urandom_range(0, 7))
        0:       val = 0;
        1:       val = 1;
        2:       val = 2;
        3:       val = TBL_DEPTH;
        4:       val = $urandom_range(TBL_DEPTH + 1, 127);
        default: val = $urandom_range(3, TBL_DEPTH - 1);
      endcase
      set_reg(REG_TABLE_POINTS, val);
      if (tbl_en_q) load_table();

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          push_convert(rand_raw());
        end else begin
          // rewrite a segment; now and then with an out-of-order breakpoint
          idx = 6'($urandom());
          push_entry(idx, ($urandom_range(0, 2) == 0) ? $urandom() : stim_bp[idx],
                     rand_q(), rand_q());
        end
      end
      drain_and_pause();
    end

    drain_and_pause();
    if (errors == 0) begin
      $display("analog_input_scaler_unit_tb: clean");
    end else begin
      $display("analog_input_scaler_unit_tb: errors");
    end
    $finish;
  end

endmodule
